### sv/mtg_pkg.sv
// Shared types, constants and arithmetic helpers for the mesh tangent generator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mtg_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int FRAC_BITS    = 16;
   localparam int IDX_W        = 10;
   localparam int ADDR_W       = $clog2(MAX_VERTICES);

   localparam int CMDQ_DEPTH   = 2;
   localparam int CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);

   localparam int DIV_STEPS    = 64;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);
   localparam int SQRT_STEPS   = 32;
   localparam int SQRT_CNT_W   = $clog2(SQRT_STEPS + 1);

   localparam logic [63:0]        SAT64     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0]        SAT64_NEG = 64'h8000_0000_0000_0001;
   localparam logic signed [32:0] DIFF_MAX  = 33'sd2147483647;
   localparam logic signed [32:0] DIFF_MIN  = -33'sd2147483647;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_TRI  = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      K_LOAD = 2'd0,
      K_TRI  = 2'd1,
      K_READ = 2'd2,
      K_BAD  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [IDX_W-1:0]   ia;
      logic [IDX_W-1:0]   ib;
      logic [IDX_W-1:0]   ic;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] tex_u;
      logic signed [31:0] tex_v;
      logic signed [17:0] nrm_x;
      logic signed [17:0] nrm_y;
      logic signed [17:0] nrm_z;
   } cmd_type;

   typedef struct packed {
      logic        start;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] q;
   } div_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] x;
   } sqrt_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] root;
   } sqrt_rsp_type;

   function automatic logic signed [31:0] sat_diff32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
      logic signed [32:0] d;
      d = {a[31], a} - {b[31], b};
      if (d > DIFF_MAX) return DIFF_MAX[31:0];
      else if (d < DIFF_MIN) return DIFF_MIN[31:0];
      else return d[31:0];
   endfunction

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic signed [64:0] s;
      s = $signed({a[63], a}) + $signed({b[63], b});
      if (s > $signed({1'b0, SAT64})) return SAT64;
      else if (s < $signed({1'b1, SAT64_NEG})) return SAT64_NEG;
      else return s[63:0];
   endfunction

   function automatic logic [63:0] mag64(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic logic idx_bad(input logic [IDX_W-1:0] idx);
      return {1'b0, idx} >= (IDX_W+1)'(MAX_VERTICES);
   endfunction

endpackage

`default_nettype wire

### sv/mtg_front.sv
// Front end: takes request words, checks indexes and sorts them into commands.
// Depends on mtg_pkg.
`default_nettype none

module mtg_front (
   input  wire logic                     req_push,
   output logic                          req_full,
   input  wire logic [1:0]               req_op,
   input  wire logic [mtg_pkg::IDX_W-1:0] req_index_a,
   input  wire logic [mtg_pkg::IDX_W-1:0] req_index_b,
   input  wire logic [mtg_pkg::IDX_W-1:0] req_index_c,
   input  wire logic signed [31:0]       req_pos_x,
   input  wire logic signed [31:0]       req_pos_y,
   input  wire logic signed [31:0]       req_pos_z,
   input  wire logic signed [31:0]       req_tex_u,
   input  wire logic signed [31:0]       req_tex_v,
   input  wire logic signed [17:0]       req_nrm_x,
   input  wire logic signed [17:0]       req_nrm_y,
   input  wire logic signed [17:0]       req_nrm_z,
   input  wire logic                     q_full,
   output logic                          q_push,
   output mtg_pkg::cmd_type              q_cmd
);
   import mtg_pkg::*;

   logic keep;
   logic bad_a, bad_any;

   assign bad_a   = idx_bad(req_index_a);
   assign bad_any = bad_a | idx_bad(req_index_b) | idx_bad(req_index_c);

   always_comb begin
      q_cmd.ia    = req_index_a;
      q_cmd.ib    = req_index_b;
      q_cmd.ic    = req_index_c;
      q_cmd.pos_x = req_pos_x;
      q_cmd.pos_y = req_pos_y;
      q_cmd.pos_z = req_pos_z;
      q_cmd.tex_u = req_tex_u;
      q_cmd.tex_v = req_tex_v;
      q_cmd.nrm_x = req_nrm_x;
      q_cmd.nrm_y = req_nrm_y;
      q_cmd.nrm_z = req_nrm_z;
      keep        = 1'b1;
      q_cmd.kind  = K_BAD;
      unique case (op_type'(req_op))
         OP_LOAD: begin
            q_cmd.kind = K_LOAD;
            keep       = ~bad_a;   // out-of-range load is dropped
         end
         OP_TRI:  q_cmd.kind = bad_any ? K_BAD : K_TRI;
         OP_READ: q_cmd.kind = bad_a ? K_BAD : K_READ;
         OP_NONE: keep = 1'b0;
         default: keep = 1'b0;
      endcase
   end

   assign req_full = q_full;
   assign q_push   = req_push & ~q_full & keep;

endmodule

`default_nettype wire

### sv/mtg_cmdq.sv
// Short command queue between front end and back end.
// Depends on mtg_pkg.
`default_nettype none

module mtg_cmdq (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire mtg_pkg::cmd_type push_cmd,
   output logic               full,
   input  wire logic          pop,
   output logic               valid,
   output mtg_pkg::cmd_type   head
);
   import mtg_pkg::*;

   cmd_type                 q_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_PTR_W:0]     cnt_ff, cnt_in;
   logic                    do_push, do_pop;

   assign full    = (cnt_ff == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
   assign valid   = (cnt_ff != '0);
   assign head    = q_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) q_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

`default_nettype wire

### sv/mtg_div.sv
// Restoring divider, one quotient bit per cycle: {hi,lo} / den, saturated.
// Depends on mtg_pkg.
`default_nettype none

module mtg_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mtg_pkg::div_req_type req,
   output mtg_pkg::div_rsp_type     rsp
);
   import mtg_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]          rem_ff, rem_in;
   logic [63:0]          lo_ff, lo_in;
   logic [63:0]          q_ff, q_in;
   logic [63:0]          d_ff, d_in;
   logic [63:0]          sh;
   logic                 ge;

   assign sh = {rem_ff[62:0], lo_ff[63]};
   assign ge = rem_ff[63] | (sh >= d_ff);   // carry out of the shift counts too

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      if (req.start) begin
         if (req.hi >= req.den) begin
            q_in    = SAT64;
            done_in = 1'b1;
         end else begin
            rem_in  = req.hi;
            lo_in   = req.lo;
            d_in    = req.den;
            q_in    = '0;
            cnt_in  = DIV_CNT_W'(DIV_STEPS);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? sh - d_ff : sh;
         lo_in  = {lo_ff[62:0], 1'b0};
         q_in   = {q_ff[62:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
   end

   assign rsp.done = done_ff;
   assign rsp.q    = (q_ff > SAT64) ? SAT64 : q_ff;

endmodule

`default_nettype wire

### sv/mtg_sqrt.sv
// Floor square root of a 64-bit word, two radicand bits per cycle.
// Depends on mtg_pkg.
`default_nettype none

module mtg_sqrt (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mtg_pkg::sqrt_req_type req,
   output mtg_pkg::sqrt_rsp_type     rsp
);
   import mtg_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]           x_ff, x_in;
   logic [63:0]           r_ff, r_in;
   logic [63:0]           bit_ff, bit_in;
   logic [63:0]           trial;

   assign trial = r_ff + bit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      if (req.start) begin
         x_in    = req.x;
         r_in    = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         cnt_in  = SQRT_CNT_W'(SQRT_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in = x_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == SQRT_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = r_ff;

endmodule

`default_nettype wire

### sv/mtg_back.sv
// Back end: vertex and accumulator memories, shared multiplier, sequencer,
// result register. Uses mtg_div and mtg_sqrt; depends on mtg_pkg.
`default_nettype none

module mtg_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     cmd_valid,
   input  wire mtg_pkg::cmd_type         cmd_head,
   output logic                          cmd_pop,
   input  wire logic                     rsp_pop,
   output logic                          rsp_valid,
   output logic [mtg_pkg::IDX_W-1:0]     rsp_vertex_id,
   output logic signed [17:0]            rsp_tan_x,
   output logic signed [17:0]            rsp_tan_y,
   output logic signed [17:0]            rsp_tan_z,
   output logic                          rsp_degenerate
);
   import mtg_pkg::*;

   typedef enum logic [18:0] {
      ST_IDLE     = 19'h00001,
      ST_T_RDB    = 19'h00002,
      ST_T_RDC    = 19'h00004,
      ST_T_GETC   = 19'h00008,
      ST_T_MUL    = 19'h00010,
      ST_T_DET    = 19'h00020,
      ST_T_DIV    = 19'h00040,
      ST_T_ACCRD  = 19'h00080,
      ST_T_ACCWR  = 19'h00100,
      ST_R_GET    = 19'h00200,
      ST_N_MAG    = 19'h00400,
      ST_N_SHIFT  = 19'h00800,
      ST_N_SQ     = 19'h01000,
      ST_N_SQRT   = 19'h02000,
      ST_N_DIV    = 19'h04000,
      ST_R_DOT    = 19'h08000,
      ST_R_DOTFIX = 19'h10000,
      ST_R_W      = 19'h20000,
      ST_RESP     = 19'h40000
   } state_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] tex_u;
      logic signed [31:0] tex_v;
      logic signed [17:0] nrm_x;
      logic signed [17:0] nrm_y;
      logic signed [17:0] nrm_z;
   } vrow_type;

   typedef logic [2:0][63:0] trow_type;

   // memories
   vrow_type    vmem [MAX_VERTICES];
   trow_type    tmem [MAX_VERTICES];
   vrow_type    vrd_ff;
   trow_type    trd_ff;
   logic [ADDR_W-1:0] vaddr, traddr, twaddr;
   logic        vwe, twe;
   vrow_type    vwdata;
   trow_type    twdata;

   state_type   state_ff, state_in;
   logic        wait_ff, wait_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        phase_ff, phase_in;

   cmd_type     cmd_ff, cmd_in;
   vrow_type    pa_ff, pa_in;
   logic signed [31:0] e1_ff [3], e1_in [3];
   logic signed [31:0] e2_ff [3], e2_in [3];
   logic signed [31:0] du1_ff, du1_in, dv1_ff, dv1_in, du2_ff, du2_in, dv2_ff, dv2_in;
   logic signed [63:0] res_ff [4], res_in [4];
   logic signed [63:0] tmp_ff, tmp_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] mul_a, mul_b;
   logic [3:0]  mstep_ff, mstep_in;
   logic [3:0]  mj;
   logic [1:0]  kidx_ff, kidx_in;
   logic [63:0] tri_t_ff [3], tri_t_in [3];
   logic [63:0] vec_ff [3], vec_in [3];
   logic [2:0]  sgn_ff, sgn_in;
   logic [63:0] m_ff [3], m_in [3];
   logic [63:0] acc_ff, acc_in;
   logic [63:0] len_ff, len_in;
   logic [63:0] nout_ff [3], nout_in [3];
   logic signed [17:0] nrm_ff [3], nrm_in [3];
   logic signed [31:0] dot_ff, dot_in;
   logic        pend_deg_ff, pend_deg_in, pend_zero_ff, pend_zero_in;
   logic [IDX_W-1:0]   rid_ff, rid_in;
   logic signed [17:0] rtan_ff [3], rtan_in [3];
   logic        rdeg_ff, rdeg_in;

   div_req_type  div_req;
   div_rsp_type  div_rsp;
   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;

   logic [63:0] mx01, mx;
   logic [63:0] num_sel, num_mag, det_mag, m_sel, q_neg, dot_neg;
   logic [IDX_W-1:0] acc_vid;
   logic        num_neg;

   mtg_div  u_div  (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));
   mtg_sqrt u_sqrt (.clock(clock), .reset(reset), .req(sqrt_req), .rsp(sqrt_rsp));

   // ---- helpers ------------------------------------------------------------
   assign mx01    = (m_ff[0] > m_ff[1]) ? m_ff[0] : m_ff[1];
   assign mx      = (mx01 > m_ff[2]) ? mx01 : m_ff[2];
   assign mj      = mstep_ff - 1'b1;
   assign q_neg   = 64'd0 - div_rsp.q;
   assign det_mag = mag64(res_ff[0]);
   assign num_mag = mag64(num_sel);
   assign num_neg = num_sel[63] ^ res_ff[0][63];
   assign dot_neg = 64'd0 - ((64'd0 - acc_ff) >> FRAC_BITS);

   always_comb begin
      unique case (kidx_ff)
         2'd0:    begin num_sel = res_ff[1]; m_sel = m_ff[0]; acc_vid = cmd_ff.ia; end
         2'd1:    begin num_sel = res_ff[2]; m_sel = m_ff[1]; acc_vid = cmd_ff.ib; end
         default: begin num_sel = res_ff[3]; m_sel = m_ff[2]; acc_vid = cmd_ff.ic; end
      endcase
   end

   // shared multiplier, operands chosen by state and step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_T_MUL) begin
         unique case (mstep_ff)
            4'd0:    begin mul_a = du1_ff; mul_b = dv2_ff;   end
            4'd1:    begin mul_a = du2_ff; mul_b = dv1_ff;   end
            4'd2:    begin mul_a = dv2_ff; mul_b = e1_ff[0]; end
            4'd3:    begin mul_a = dv1_ff; mul_b = e2_ff[0]; end
            4'd4:    begin mul_a = dv2_ff; mul_b = e1_ff[1]; end
            4'd5:    begin mul_a = dv1_ff; mul_b = e2_ff[1]; end
            4'd6:    begin mul_a = dv2_ff; mul_b = e1_ff[2]; end
            4'd7:    begin mul_a = dv1_ff; mul_b = e2_ff[2]; end
            default: ;
         endcase
      end else if (state_ff == ST_N_SQ) begin
         unique case (mstep_ff)
            4'd0:    begin mul_a = m_ff[0][31:0]; mul_b = m_ff[0][31:0]; end
            4'd1:    begin mul_a = m_ff[1][31:0]; mul_b = m_ff[1][31:0]; end
            4'd2:    begin mul_a = m_ff[2][31:0]; mul_b = m_ff[2][31:0]; end
            default: ;
         endcase
      end else if (state_ff == ST_R_DOT) begin
         unique case (mstep_ff)
            4'd0:    begin mul_a = 32'(nrm_ff[0]); mul_b = nout_ff[0][31:0]; end
            4'd1:    begin mul_a = 32'(nrm_ff[1]); mul_b = nout_ff[1][31:0]; end
            4'd2:    begin mul_a = 32'(nrm_ff[2]); mul_b = nout_ff[2][31:0]; end
            default: ;
         endcase
      end else if (state_ff == ST_R_W) begin
         unique case (mstep_ff)
            4'd0:    mul_a = 32'(nrm_ff[0]);
            4'd1:    mul_a = 32'(nrm_ff[1]);
            4'd2:    mul_a = 32'(nrm_ff[2]);
            default: ;
         endcase
         mul_b = dot_ff;
      end
   end

   assign prod_in = mul_a * mul_b;

   // ---- memory ports ---------------------------------------------------------
   always_comb begin
      vwdata.pos_x = cmd_head.pos_x;
      vwdata.pos_y = cmd_head.pos_y;
      vwdata.pos_z = cmd_head.pos_z;
      vwdata.tex_u = cmd_head.tex_u;
      vwdata.tex_v = cmd_head.tex_v;
      vwdata.nrm_x = cmd_head.nrm_x;
      vwdata.nrm_y = cmd_head.nrm_y;
      vwdata.nrm_z = cmd_head.nrm_z;
      vwe    = cmd_pop && (cmd_head.kind == K_LOAD);
      twe    = vwe;
      twaddr = cmd_head.ia[ADDR_W-1:0];
      twdata = '0;
      if (state_ff == ST_T_ACCWR) begin
         twe    = 1'b1;
         twaddr = acc_vid[ADDR_W-1:0];
         twdata[0] = sat_add64(trd_ff[0], tri_t_ff[0]);
         twdata[1] = sat_add64(trd_ff[1], tri_t_ff[1]);
         twdata[2] = sat_add64(trd_ff[2], tri_t_ff[2]);
      end
      unique case (state_ff)
         ST_IDLE:  vaddr = cmd_head.ia[ADDR_W-1:0];
         ST_T_RDB: vaddr = cmd_ff.ib[ADDR_W-1:0];
         ST_T_RDC: vaddr = cmd_ff.ic[ADDR_W-1:0];
         default:  vaddr = cmd_ff.ia[ADDR_W-1:0];
      endcase
      traddr = (state_ff == ST_IDLE) ? cmd_head.ia[ADDR_W-1:0] : acc_vid[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (vwe) vmem[cmd_head.ia[ADDR_W-1:0]] <= vwdata;
      vrd_ff <= vmem[vaddr];
   end

   always_ff @(posedge clock) begin
      if (twe) tmem[twaddr] <= twdata;
      trd_ff <= tmem[traddr];
   end

   // ---- sequencer ------------------------------------------------------------
   assign cmd_pop = (state_ff == ST_IDLE) && cmd_valid;

   always_comb begin
      div_req.start  = ((state_ff == ST_T_DIV) || (state_ff == ST_N_DIV)) && !wait_ff;
      div_req.hi     = (state_ff == ST_T_DIV) ? (num_mag >> (64 - FRAC_BITS)) : 64'd0;
      div_req.lo     = (state_ff == ST_T_DIV) ? (num_mag << FRAC_BITS) : (m_sel << FRAC_BITS);
      div_req.den    = (state_ff == ST_T_DIV) ? det_mag : len_ff;
      sqrt_req.start = (state_ff == ST_N_SQRT) && !wait_ff;
      sqrt_req.x     = acc_ff;
   end

   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      phase_in     = phase_ff;
      cmd_in       = cmd_ff;
      pa_in        = pa_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      du1_in       = du1_ff;
      dv1_in       = dv1_ff;
      du2_in       = du2_ff;
      dv2_in       = dv2_ff;
      res_in       = res_ff;
      tmp_in       = tmp_ff;
      mstep_in     = mstep_ff;
      kidx_in      = kidx_ff;
      tri_t_in     = tri_t_ff;
      vec_in       = vec_ff;
      sgn_in       = sgn_ff;
      m_in         = m_ff;
      acc_in       = acc_ff;
      len_in       = len_ff;
      nout_in      = nout_ff;
      nrm_in       = nrm_ff;
      dot_in       = dot_ff;
      pend_deg_in  = pend_deg_ff;
      pend_zero_in = pend_zero_ff;
      rid_in       = rid_ff;
      rtan_in      = rtan_ff;
      rdeg_in      = rdeg_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_pop;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd_head;
               unique case (cmd_head.kind)
                  K_LOAD: state_in = ST_IDLE;
                  K_TRI:  state_in = ST_T_RDB;
                  K_READ: state_in = ST_R_GET;
                  K_BAD: begin
                     pend_deg_in  = 1'b1;
                     pend_zero_in = 1'b1;
                     state_in     = ST_RESP;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_T_RDB: begin
            pa_in    = vrd_ff;
            state_in = ST_T_RDC;
         end
         ST_T_RDC: begin
            e1_in[0] = sat_diff32(vrd_ff.pos_x, pa_ff.pos_x);
            e1_in[1] = sat_diff32(vrd_ff.pos_y, pa_ff.pos_y);
            e1_in[2] = sat_diff32(vrd_ff.pos_z, pa_ff.pos_z);
            du1_in   = sat_diff32(vrd_ff.tex_u, pa_ff.tex_u);
            dv1_in   = sat_diff32(vrd_ff.tex_v, pa_ff.tex_v);
            state_in = ST_T_GETC;
         end
         ST_T_GETC: begin
            e2_in[0] = sat_diff32(vrd_ff.pos_x, pa_ff.pos_x);
            e2_in[1] = sat_diff32(vrd_ff.pos_y, pa_ff.pos_y);
            e2_in[2] = sat_diff32(vrd_ff.pos_z, pa_ff.pos_z);
            du2_in   = sat_diff32(vrd_ff.tex_u, pa_ff.tex_u);
            dv2_in   = sat_diff32(vrd_ff.tex_v, pa_ff.tex_v);
            mstep_in = '0;
            state_in = ST_T_MUL;
         end
         ST_T_MUL: begin
            // prod_ff holds the product launched one step earlier
            if (mstep_ff != 4'd0) begin
               if (!mj[0]) tmp_in = prod_ff;
               else res_in[mj[2:1]] = tmp_ff - prod_ff;
            end
            mstep_in = mstep_ff + 1'b1;
            if (mstep_ff == 4'd8) state_in = ST_T_DET;
         end
         ST_T_DET: begin
            if (res_ff[0] == 64'sd0) begin
               pend_deg_in  = 1'b1;
               pend_zero_in = 1'b1;
               state_in     = ST_RESP;
            end else begin
               kidx_in  = 2'd0;
               wait_in  = 1'b0;
               state_in = ST_T_DIV;
            end
         end
         ST_T_DIV: begin
            if (!wait_ff) wait_in = 1'b1;
            if (div_rsp.done) begin
               wait_in           = 1'b0;
               tri_t_in[kidx_ff] = num_neg ? q_neg : div_rsp.q;
               kidx_in           = kidx_ff + 1'b1;
               if (kidx_ff == 2'd2) begin
                  kidx_in  = 2'd0;
                  state_in = ST_T_ACCRD;
               end
            end
         end
         ST_T_ACCRD: state_in = ST_T_ACCWR;
         ST_T_ACCWR: begin
            kidx_in  = kidx_ff + 1'b1;
            state_in = ST_T_ACCRD;
            if (kidx_ff == 2'd2) begin
               pend_deg_in  = 1'b0;
               pend_zero_in = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_R_GET: begin
            nrm_in[0] = vrd_ff.nrm_x;
            nrm_in[1] = vrd_ff.nrm_y;
            nrm_in[2] = vrd_ff.nrm_z;
            vec_in[0] = trd_ff[0];
            vec_in[1] = trd_ff[1];
            vec_in[2] = trd_ff[2];
            phase_in  = 1'b0;
            state_in  = ST_N_MAG;
         end
         ST_N_MAG: begin
            for (int k = 0; k < 3; k++) begin
               m_in[k]   = mag64(vec_ff[k]);
               sgn_in[k] = vec_ff[k][63];
            end
            state_in = ST_N_SHIFT;
         end
         ST_N_SHIFT: begin
            // bring the largest magnitude into [2^30, 2^31), one bit a cycle
            if (mx == 64'd0) begin
               pend_deg_in  = 1'b1;
               pend_zero_in = 1'b1;
               state_in     = ST_RESP;
            end else if (mx[63:31] != '0) begin
               for (int k = 0; k < 3; k++) m_in[k] = m_ff[k] >> 1;
            end else if (!mx[30]) begin
               for (int k = 0; k < 3; k++) m_in[k] = m_ff[k] << 1;
            end else begin
               mstep_in = '0;
               acc_in   = '0;
               state_in = ST_N_SQ;
            end
         end
         ST_N_SQ: begin
            if (mstep_ff != 4'd0) acc_in = acc_ff + prod_ff;
            mstep_in = mstep_ff + 1'b1;
            if (mstep_ff == 4'd3) begin
               wait_in  = 1'b0;
               state_in = ST_N_SQRT;
            end
         end
         ST_N_SQRT: begin
            if (!wait_ff) wait_in = 1'b1;
            if (sqrt_rsp.done) begin
               wait_in  = 1'b0;
               len_in   = sqrt_rsp.root;
               kidx_in  = 2'd0;
               state_in = ST_N_DIV;
            end
         end
         ST_N_DIV: begin
            if (!wait_ff) wait_in = 1'b1;
            if (div_rsp.done) begin
               wait_in          = 1'b0;
               nout_in[kidx_ff] = sgn_ff[kidx_ff] ? q_neg : div_rsp.q;
               kidx_in          = kidx_ff + 1'b1;
               if (kidx_ff == 2'd2) begin
                  kidx_in = 2'd0;
                  if (!phase_ff) begin
                     mstep_in = '0;
                     acc_in   = '0;
                     state_in = ST_R_DOT;
                  end else begin
                     pend_deg_in  = 1'b0;
                     pend_zero_in = 1'b0;
                     state_in     = ST_RESP;
                  end
               end
            end
         end
         ST_R_DOT: begin
            if (mstep_ff != 4'd0) acc_in = acc_ff + prod_ff;
            mstep_in = mstep_ff + 1'b1;
            if (mstep_ff == 4'd3) state_in = ST_R_DOTFIX;
         end
         ST_R_DOTFIX: begin
            // divide by 2^FRAC_BITS, truncating toward zero
            dot_in   = acc_ff[63] ? dot_neg[31:0] : 32'(acc_ff >> FRAC_BITS);
            mstep_in = '0;
            state_in = ST_R_W;
         end
         ST_R_W: begin
            if (mstep_ff != 4'd0) vec_in[mj[1:0]] = (nout_ff[mj[1:0]] << FRAC_BITS) - prod_ff;
            mstep_in = mstep_ff + 1'b1;
            if (mstep_ff == 4'd3) begin
               phase_in = 1'b1;
               state_in = ST_N_MAG;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_in) begin
               rsp_valid_in = 1'b1;
               rid_in       = cmd_ff.ia;
               rdeg_in      = pend_deg_ff;
               for (int k = 0; k < 3; k++)
                  rtan_in[k] = pend_zero_ff ? 18'sd0 : nout_ff[k][17:0];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff     <= phase_in;
      cmd_ff       <= cmd_in;
      pa_ff        <= pa_in;
      e1_ff        <= e1_in;
      e2_ff        <= e2_in;
      du1_ff       <= du1_in;
      dv1_ff       <= dv1_in;
      du2_ff       <= du2_in;
      dv2_ff       <= dv2_in;
      res_ff       <= res_in;
      tmp_ff       <= tmp_in;
      prod_ff      <= prod_in;
      mstep_ff     <= mstep_in;
      kidx_ff      <= kidx_in;
      tri_t_ff     <= tri_t_in;
      vec_ff       <= vec_in;
      sgn_ff       <= sgn_in;
      m_ff         <= m_in;
      acc_ff       <= acc_in;
      len_ff       <= len_in;
      nout_ff      <= nout_in;
      nrm_ff       <= nrm_in;
      dot_ff       <= dot_in;
      pend_deg_ff  <= pend_deg_in;
      pend_zero_ff <= pend_zero_in;
      rid_ff       <= rid_in;
      rtan_ff      <= rtan_in;
      rdeg_ff      <= rdeg_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_vertex_id  = rid_ff;
   assign rsp_tan_x      = rtan_ff[0];
   assign rsp_tan_y      = rtan_ff[1];
   assign rsp_tan_z      = rtan_ff[2];
   assign rsp_degenerate = rdeg_ff;

endmodule

`default_nettype wire

### sv/mesh_tangent_generator_top.sv
// Mesh tangent generator top level. In the back end a load is written from the idle state; a triangle
// takes three vertex reads, 8 multiplies, three divides and three accumulator
// read-modify-writes; a read takes two normalizations, each a shift search, a square
// root and three divides.
// One word is processed at a time behind a two-entry command queue.
// Synchronous active-high reset clears control only; vertex memories start unknown.
`default_nettype none

module mesh_tangent_generator_top (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_push,
   output logic                          req_full,
   input  wire logic [1:0]               req_op,
   input  wire logic [mtg_pkg::IDX_W-1:0] req_index_a,
   input  wire logic [mtg_pkg::IDX_W-1:0] req_index_b,
   input  wire logic [mtg_pkg::IDX_W-1:0] req_index_c,
   input  wire logic signed [31:0]       req_pos_x,
   input  wire logic signed [31:0]       req_pos_y,
   input  wire logic signed [31:0]       req_pos_z,
   input  wire logic signed [31:0]       req_tex_u,
   input  wire logic signed [31:0]       req_tex_v,
   input  wire logic signed [17:0]       req_nrm_x,
   input  wire logic signed [17:0]       req_nrm_y,
   input  wire logic signed [17:0]       req_nrm_z,
   output logic                          rsp_empty,
   input  wire logic                     rsp_pop,
   output logic [mtg_pkg::IDX_W-1:0]     rsp_vertex_id,
   output logic signed [17:0]            rsp_tan_x,
   output logic signed [17:0]            rsp_tan_y,
   output logic signed [17:0]            rsp_tan_z,
   output logic                          rsp_degenerate
);
   import mtg_pkg::*;

   cmd_type push_cmd, head;
   logic    q_push, q_full, q_valid, q_pop, rsp_valid;

   mtg_front u_front (
      .req_push   (req_push),
      .req_full   (req_full),
      .req_op     (req_op),
      .req_index_a(req_index_a),
      .req_index_b(req_index_b),
      .req_index_c(req_index_c),
      .req_pos_x  (req_pos_x),
      .req_pos_y  (req_pos_y),
      .req_pos_z  (req_pos_z),
      .req_tex_u  (req_tex_u),
      .req_tex_v  (req_tex_v),
      .req_nrm_x  (req_nrm_x),
      .req_nrm_y  (req_nrm_y),
      .req_nrm_z  (req_nrm_z),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   mtg_cmdq u_cmdq (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_cmd(push_cmd),
      .full    (q_full),
      .pop     (q_pop),
      .valid   (q_valid),
      .head    (head)
   );

   mtg_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (q_valid),
      .cmd_head      (head),
      .cmd_pop       (q_pop),
      .rsp_pop       (rsp_pop & rsp_valid),
      .rsp_valid     (rsp_valid),
      .rsp_vertex_id (rsp_vertex_id),
      .rsp_tan_x     (rsp_tan_x),
      .rsp_tan_y     (rsp_tan_y),
      .rsp_tan_z     (rsp_tan_z),
      .rsp_degenerate(rsp_degenerate)
   );

   assign rsp_empty = ~rsp_valid;

endmodule

`default_nettype wire
